### src/imh_pkg.sv
package imh_pkg;

  localparam int NodeIdW    = 10;
  localparam int PortCostW  = 32;
  localparam int NodesUsedW = 11;
  localparam int CfgDataW   = 32;
  localparam int CfgIndexW  = 1;

  typedef enum logic [1:0] {
    CmdResetAll  = 2'd0,
    CmdDecrease  = 2'd1,
    CmdRemoveMin = 2'd2,
    CmdReadCost  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIndexW-1:0] {
    CfgNodesUsed    = 1'b0,
    CfgInfinityCost = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    StIdle,
    StSweep,
    StDPos,
    StDSlot,
    StUp,
    StQPos,
    StQSlot,
    StRmFirst,
    StRmLast,
    StDnA,
    StDnB,
    StDnC,
    StPlace,
    StResult
  } state_e;

endpackage

### src/imh_if.sv
interface imh_cmd_if import imh_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic [NodeIdW-1:0]   node_id;
  logic [PortCostW-1:0] new_cost;
  modport source (output valid, command, node_id, new_cost, input ready);
  modport sink   (input valid, command, node_id, new_cost, output ready);
endinterface

interface imh_res_if import imh_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [NodeIdW-1:0]   result_node;
  logic [PortCostW-1:0] result_cost;
  logic                 cost_raised_error;
  modport source (output valid, result_node, result_cost, cost_raised_error, input ready);
  modport sink   (input valid, result_node, result_cost, cost_raised_error, output ready);
endinterface

interface imh_cfg_if import imh_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/imh_ram.sv
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/indexed_min_heap_decrease_key_top.sv
// channel  dir  words                                      handshake
// cmd_i    in   command, node_id, new_cost                 valid/ready
// res_o    out  result_node, result_cost, cost_raised_error valid/ready
// cfg_i    in   index, data (nodes_used, infinity_cost)    valid/ready, always ready
//
// one command word at a time; decrease cost climbs level by level, remove minimum
// descends level by level reading both children, reset all sweeps every entry in
// use; the heap memory read port sets the pace
// after reset a clearing pass over all NODES entries loads identity order, no command taken
// a finished result waits in the output register; a new command is taken meanwhile
module indexed_min_heap_decrease_key_top import imh_pkg::*; #(
  parameter int NODES      = 1024,
  parameter int COST_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  imh_cmd_if.sink   cmd_i,
  imh_res_if.source res_o,
  imh_cfg_if.sink   cfg_i
);

  localparam int IW = $clog2(NODES);      // slot / node index
  localparam int NW = $clog2(NODES + 1);  // entry count
  localparam int XW = NW + 1;             // child index, may pass the count
  localparam int EW = IW + COST_WIDTH;    // heap entry: node above cost
  localparam logic [COST_WIDTH-1:0] InfRst = COST_WIDTH'(64'hFFFF_FFFF);

  // configuration registers
  logic [NodesUsedW-1:0] nodes_used_q;
  logic [PortCostW-1:0]  infinity_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_used_q <= NodesUsedW'(1024);
      infinity_q   <= '1;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CfgNodesUsed:    nodes_used_q <= cfg_i.data[NodesUsedW-1:0];
        CfgInfinityCost: infinity_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // live entry count, clamped to one..NODES
  logic [NW-1:0]         n_c;
  logic [COST_WIDTH-1:0] inf_c;

  always_comb begin
    if (nodes_used_q == '0) begin
      n_c = NW'(1);
    end else if (32'(nodes_used_q) > 32'(NODES)) begin
      n_c = NW'(NODES);
    end else begin
      n_c = NW'(nodes_used_q);
    end
  end

  assign inf_c = COST_WIDTH'(infinity_q);

  // heap slots and node-to-slot table
  logic          h_we;
  logic [IW-1:0] h_waddr, h_raddr;
  logic [EW-1:0] h_wdata, h_rdata;
  logic          p_we;
  logic [IW-1:0] p_waddr, p_raddr, p_wdata, p_rdata;

  imh_ram #(.WIDTH(EW), .DEPTH(NODES)) u_heap (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  imh_ram #(.WIDTH(IW), .DEPTH(NODES)) u_pos (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  logic [IW-1:0]         h_rnode;
  logic [COST_WIDTH-1:0] h_rcost;

  assign h_rnode = h_rdata[EW-1:COST_WIDTH];
  assign h_rcost = h_rdata[COST_WIDTH-1:0];

  // control and working registers
  state_e                state_q, state_d;
  logic                  boot_q, boot_d;
  logic [NW-1:0]         cnt_q, cnt_d;
  logic [NW-1:0]         lim_q, lim_d;
  logic [COST_WIDTH-1:0] sweep_inf_q, sweep_inf_d;
  logic [COST_WIDTH-1:0] cost_q, cost_d;
  logic [IW-1:0]         slot_q, slot_d;
  logic [IW-1:0]         cur_node_q, cur_node_d;
  logic [COST_WIDTH-1:0] cur_cost_q, cur_cost_d;
  logic [IW-1:0]         a_node_q, a_node_d;
  logic [COST_WIDTH-1:0] a_cost_q, a_cost_d;
  logic [XW-1:0]         chi_q, chi_d;
  logic [NodeIdW-1:0]    res_node_q, res_node_d;
  logic [PortCostW-1:0]  res_cost_q, res_cost_d;
  logic                  res_err_q, res_err_d;
  logic                  out_load;

  logic                  out_valid_q;
  logic [NodeIdW-1:0]    out_node_q;
  logic [PortCostW-1:0]  out_cost_q;
  logic                  out_err_q;
  logic                  out_free;

  assign out_free    = !out_valid_q || res_o.ready;
  assign cmd_i.ready = (state_q == StIdle);

  // helpers
  logic          in_rng;
  logic [IW-1:0] last_slot;
  logic [IW-1:0] par_slot;
  logic [XW-1:0] n_x;
  logic          have2;
  logic          pick_b;
  logic [IW-1:0] ci;
  logic [XW-1:0] next_c;

  assign in_rng    = 32'(cmd_i.node_id) < 32'(n_c);
  assign last_slot = IW'(n_c - NW'(1));
  assign par_slot  = IW'((slot_q - IW'(1)) >> 1);
  assign n_x       = XW'(n_c);
  assign have2     = (chi_q + XW'(1)) < n_x;
  assign pick_b    = have2 && (a_cost_q > h_rcost);
  assign ci        = pick_b ? IW'(chi_q + XW'(1)) : IW'(chi_q);
  assign next_c    = XW'({ci, 1'b1});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StSweep;
      boot_q      <= 1'b1;
      cnt_q       <= '0;
      lim_q       <= NW'(NODES);
      sweep_inf_q <= InfRst;
    end else begin
      state_q     <= state_d;
      boot_q      <= boot_d;
      cnt_q       <= cnt_d;
      lim_q       <= lim_d;
      sweep_inf_q <= sweep_inf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cost_q     <= cost_d;
    slot_q     <= slot_d;
    cur_node_q <= cur_node_d;
    cur_cost_q <= cur_cost_d;
    a_node_q   <= a_node_d;
    a_cost_q   <= a_cost_d;
    chi_q      <= chi_d;
    res_node_q <= res_node_d;
    res_cost_q <= res_cost_d;
    res_err_q  <= res_err_d;
  end

  always_comb begin
    state_d     = state_q;
    boot_d      = boot_q;
    cnt_d       = cnt_q;
    lim_d       = lim_q;
    sweep_inf_d = sweep_inf_q;
    cost_d      = cost_q;
    slot_d      = slot_q;
    cur_node_d  = cur_node_q;
    cur_cost_d  = cur_cost_q;
    a_node_d    = a_node_q;
    a_cost_d    = a_cost_q;
    chi_d       = chi_q;
    res_node_d  = res_node_q;
    res_cost_d  = res_cost_q;
    res_err_d   = res_err_q;
    out_load    = 1'b0;

    h_we    = 1'b0;
    h_waddr = slot_q;
    h_wdata = {cur_node_q, cur_cost_q};
    h_raddr = '0;
    p_we    = 1'b0;
    p_waddr = cur_node_q;
    p_wdata = slot_q;
    p_raddr = IW'(cmd_i.node_id);

    case (state_q)
      StIdle: begin
        if (cmd_i.valid) begin
          res_node_d = '0;
          res_cost_d = '0;
          res_err_d  = 1'b0;
          cost_d     = COST_WIDTH'(cmd_i.new_cost);
          case (cmd_e'(cmd_i.command))
            CmdResetAll: begin
              cnt_d       = '0;
              lim_d       = n_c;
              sweep_inf_d = inf_c;
              state_d     = StSweep;
            end
            CmdDecrease:  state_d = in_rng ? StDPos : StResult;
            CmdRemoveMin: state_d = StRmFirst;  // heap slot zero read issued here
            CmdReadCost:  state_d = in_rng ? StQPos : StResult;
            default:      state_d = StResult;
          endcase
        end
      end

      // identity order sweep, also the clearing pass after reset
      StSweep: begin
        h_we    = 1'b1;
        h_waddr = IW'(cnt_q);
        h_wdata = {IW'(cnt_q), sweep_inf_q};
        p_we    = 1'b1;
        p_waddr = IW'(cnt_q);
        p_wdata = IW'(cnt_q);
        cnt_d   = cnt_q + NW'(1);
        if (cnt_q == lim_q - NW'(1)) begin
          boot_d  = 1'b0;
          state_d = boot_q ? StIdle : StResult;
        end
      end

      StDPos: begin
        slot_d  = p_rdata;
        h_raddr = p_rdata;
        state_d = StDSlot;
      end

      StDSlot: begin
        if (cost_q > h_rcost) begin
          res_err_d = 1'b1;
          state_d   = StResult;
        end else begin
          cur_node_d = h_rnode;
          cur_cost_d = cost_q;
          if (slot_q == '0) begin
            state_d = StPlace;
          end else begin
            h_raddr = par_slot;
            state_d = StUp;
          end
        end
      end

      // parent word arrives; move it down into the hole or settle
      StUp: begin
        if (h_rcost > cur_cost_q) begin
          h_we    = 1'b1;
          h_waddr = slot_q;
          h_wdata = h_rdata;
          p_we    = 1'b1;
          p_waddr = h_rnode;
          p_wdata = slot_q;
          slot_d  = par_slot;
          if (par_slot == '0) begin
            state_d = StPlace;
          end else begin
            h_raddr = IW'((par_slot - IW'(1)) >> 1);
          end
        end else begin
          state_d = StPlace;
        end
      end

      StQPos: begin
        h_raddr = p_rdata;
        state_d = StQSlot;
      end

      StQSlot: begin
        res_cost_d = PortCostW'(h_rcost);
        state_d    = StResult;
      end

      StRmFirst: begin
        res_node_d = NodeIdW'(h_rnode);
        res_cost_d = PortCostW'(h_rcost);
        a_node_d   = h_rnode;
        h_raddr    = last_slot;
        state_d    = StRmLast;
      end

      // park the removed node in the last slot, last word becomes the hole value
      StRmLast: begin
        cur_node_d = h_rnode;
        cur_cost_d = h_rcost;
        h_we       = 1'b1;
        h_waddr    = last_slot;
        h_wdata    = {a_node_q, inf_c};
        p_we       = 1'b1;
        p_waddr    = a_node_q;
        p_wdata    = last_slot;
        slot_d     = '0;
        chi_d      = XW'(1);
        state_d    = (n_c == NW'(1)) ? StResult : StDnA;
      end

      StDnA: begin
        h_raddr = IW'(chi_q);
        state_d = StDnB;
      end

      StDnB: begin
        a_node_d = h_rnode;
        a_cost_d = h_rcost;
        h_raddr  = IW'(chi_q + XW'(1));
        state_d  = StDnC;
      end

      // both children, or the only one, in hand; move the smaller up into the hole or settle
      StDnC: begin
        if (cur_cost_q > (pick_b ? h_rcost : a_cost_q)) begin
          h_we    = 1'b1;
          h_waddr = slot_q;
          h_wdata = pick_b ? h_rdata : {a_node_q, a_cost_q};
          p_we    = 1'b1;
          p_waddr = pick_b ? h_rnode : a_node_q;
          p_wdata = slot_q;
          slot_d  = ci;
          chi_d   = next_c;
          if (next_c < n_x) begin
            h_raddr = IW'(next_c);
            state_d = StDnB;
          end else begin
            state_d = StPlace;
          end
        end else begin
          state_d = StPlace;
        end
      end

      StPlace: begin
        h_we    = 1'b1;
        p_we    = 1'b1;
        state_d = StResult;
      end

      StResult: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_node_q <= res_node_q;
      out_cost_q <= res_cost_q;
      out_err_q  <= res_err_q;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.result_node       = out_node_q;
  assign res_o.result_cost       = out_cost_q;
  assign res_o.cost_raised_error = out_err_q;

`ifndef SYNTHESIS
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (!h_we && !p_we))
    else $error("memory written while idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> (state_q != StIdle))
    else $error("command accepted but block stayed idle");

  // sift-down hole stays among the live entries
  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDnB || state_q == StDnC)
    |-> (32'(slot_q) < 32'(n_c)))
    else $error("sift hole outside live entries");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StResult))
    else $error("result word appeared outside result state");
`endif

endmodule

### dv/tb_heap_checker.sv
`timescale 1ns / 100ps
module tb_heap_checker import imh_pkg::*; #(
  parameter int NODES = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  imh_cmd_if.sink      cmd_mon,
  imh_res_if.sink      res_mon,
  imh_cfg_if.sink      cfg_mon,
  output int unsigned  fail_count,
  output int unsigned  pending_results
);

  typedef struct packed {
    logic [NodeIdW-1:0]   node;
    logic [PortCostW-1:0] cost;
  } heap_entry_t;

  typedef struct packed {
    logic [NodeIdW-1:0]   node;
    logic [PortCostW-1:0] cost;
    logic                 raised;
  } heap_answer_t;

  heap_entry_t           heap_model [NODES];
  int unsigned           pos_model  [NODES];
  logic [NodesUsedW-1:0] used_reg;
  logic [PortCostW-1:0]  inf_reg;
  heap_answer_t          answers_q [$];

  function automatic int unsigned live_entries();
    if (used_reg == 0) return 1;
    if (used_reg > NODES) return NODES;
    return used_reg;
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    heap_entry_t t;
    t = heap_model[a];
    heap_model[a] = heap_model[b];
    heap_model[b] = t;
    pos_model[heap_model[a].node] = a;
    pos_model[heap_model[b].node] = b;
  endfunction

  function automatic void fill_identity(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      heap_model[i].node = NodeIdW'(i);
      heap_model[i].cost = inf_reg;
      pos_model[i] = i;
    end
  endfunction

  function automatic heap_answer_t apply_command(cmd_e cmd, logic [NodeIdW-1:0] id,
                                                 logic [PortCostW-1:0] cost);
    heap_answer_t r;
    int unsigned  n, s, p, c, last;
    heap_entry_t  first;
    r = '0;
    n = live_entries();
    case (cmd)
      CmdResetAll: fill_identity(n);
      CmdDecrease: begin
        if (id < n) begin
          s = pos_model[id];
          if (cost > heap_model[s].cost) r.raised = 1'b1;
          else begin
            heap_model[s].cost = cost;
            while (s > 0) begin
              p = (s - 1) / 2;
              if (heap_model[p].cost > heap_model[s].cost) begin
                swap_slots(s, p);
                s = p;
              end else break;
            end
          end
        end
      end
      CmdRemoveMin: begin
        last = n - 1;
        first = heap_model[0];
        heap_model[0] = heap_model[last];
        heap_model[last].node = first.node;
        heap_model[last].cost = inf_reg;
        pos_model[heap_model[0].node] = 0;
        pos_model[first.node] = last;
        s = 0;
        while (2 * s + 1 < n) begin
          c = 2 * s + 1;
          if (c + 1 < n && heap_model[c].cost > heap_model[c + 1].cost) c++;
          if (heap_model[s].cost > heap_model[c].cost) begin
            swap_slots(s, c);
            s = c;
          end else break;
        end
        r.node = first.node;
        r.cost = first.cost;
      end
      default: if (id < n) r.cost = heap_model[pos_model[id]].cost;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    heap_answer_t want;
    if (!rst_ni) begin
      used_reg   = NODES;
      inf_reg    = '1;
      fill_identity(NODES);
      answers_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CfgNodesUsed) used_reg = cfg_mon.data[NodesUsedW-1:0];
        else inf_reg = cfg_mon.data[PortCostW-1:0];
      end
      if (res_mon.valid && res_mon.ready) begin
        if (answers_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word node=%0d cost=%0d err=%0b",
                                        res_mon.result_node, res_mon.result_cost,
                                        res_mon.cost_raised_error);
          fail_count <= fail_count + 1;
        end else begin
          want = answers_q.pop_front();
          if (want.node !== res_mon.result_node || want.cost !== res_mon.result_cost ||
              want.raised !== res_mon.cost_raised_error) begin
            if (fail_count < 10)
              $display("mismatch: exp node=%0d cost=%0d err=%0b got node=%0d cost=%0d err=%0b",
                       want.node, want.cost, want.raised, res_mon.result_node,
                       res_mon.result_cost, res_mon.cost_raised_error);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cmd_mon.valid && cmd_mon.ready)
        answers_q.push_back(apply_command(cmd_e'(cmd_mon.command), cmd_mon.node_id,
                                          cmd_mon.new_cost));
    end
  end

  assign pending_results = answers_q.size();

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import imh_pkg::*;

  localparam int NODES = 1024;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned leftover;
  int unsigned hold_cycles;
  logic        hold_go;

  imh_cmd_if cmd_if ();
  imh_res_if res_if ();
  imh_cfg_if cfg_if ();

  indexed_min_heap_decrease_key_top #(.NODES(NODES), .COST_WIDTH(32)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if.sink),
    .res_o  (res_if.source),
    .cfg_i  (cfg_if.sink)
  );

  // checker watches all three channels and keeps the shadow heap
  tb_heap_checker #(.NODES(NODES)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_mon         (cmd_if.sink),
    .res_mon         (res_if.sink),
    .cfg_mon         (cfg_if.sink),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // gap length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // one command word, held until the block takes it
  task automatic send_word(cmd_e cmd, logic [NodeIdW-1:0] id, logic [PortCostW-1:0] cost);
    cmd_if.valid    <= 1'b1;
    cmd_if.command  <= cmd;
    cmd_if.node_id  <= id;
    cmd_if.new_cost <= cost;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
  endtask

  task automatic send_gap();
    int unsigned g;
    g = pick_gap();
    if (g > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // drain all expected words, then let a reset-all sweep finish before config
  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (NODES + 50) @(posedge clk_i);
  endtask

  // mostly well-formed shortest-path traffic on a given entry count
  task automatic random_phase(int unsigned n, int unsigned count, logic [31:0] cost_top);
    int unsigned  r;
    logic [9:0]   id;
    logic [31:0]  c;
    for (int unsigned k = 0; k < count; k++) begin
      r  = $urandom_range(0, 99);
      id = (r < 90) ? 10'($urandom_range(0, n - 1)) : 10'($urandom);
      c  = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, cost_top));
      if (r < 2) send_word(CmdResetAll, id, c);
      else if (r < 55) send_word(CmdDecrease, id, c);
      else if (r < 80) send_word(CmdRemoveMin, id, c);
      else send_word(CmdReadCost, id, c);
      if ($urandom_range(0, 3) != 0) send_gap();
    end
  endtask

  // receiver side: random stalls plus one long hold-off
  initial begin
    int unsigned g;
    res_if.ready <= 1'b0;
    hold_cycles = 0;
    @(posedge rst_ni);
    repeat (NODES + 200) @(posedge clk_i);
    while (!hold_go) begin
      g = pick_gap();
      res_if.ready <= (g == 0) || ($urandom_range(0, 1) == 0);
      @(posedge clk_i);
    end
    // long hold-off so the output register fills and the input stalls
    res_if.ready <= 1'b0;
    while (hold_cycles < 400) begin
      @(posedge clk_i);
      hold_cycles++;
    end
    forever begin
      g = pick_gap();
      res_if.ready <= (g == 0) || ($urandom_range(0, 1) == 0);
      @(posedge clk_i);
    end
  end

  initial begin
    hold_go = 1'b0;
    cmd_if.valid    <= 1'b0;
    cmd_if.command  <= CmdResetAll;
    cmd_if.node_id  <= '0;
    cmd_if.new_cost <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= CfgNodesUsed;
    cfg_if.data     <= '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: full-size heap defaults, field extremes
    send_word(CmdReadCost, 10'd0, '0);
    send_word(CmdReadCost, 10'd1023, '1);
    send_word(CmdDecrease, 10'd1023, 32'd0);
    send_word(CmdDecrease, 10'd5, 32'hFFFF_FFFF);
    send_word(CmdDecrease, 10'd5, 32'd100);
    send_word(CmdDecrease, 10'd5, 32'd100);  // equal cost accepted
    send_word(CmdDecrease, 10'd5, 32'd200);  // raise flagged
    send_word(CmdDecrease, 10'd682, 32'h5555_5555);
    send_word(CmdDecrease, 10'd341, 32'hAAAA_AAAA);
    send_word(CmdRemoveMin, 10'd0, '0);
    send_word(CmdRemoveMin, 10'd0, '0);
    send_word(CmdReadCost, 10'd1023, '0);
    send_word(CmdResetAll, 10'd0, '0);
    send_word(CmdReadCost, 10'd5, '0);
    wait_idle();

    // small heap: out-of-range nodes ignored
    write_reg(CfgNodesUsed, 32'd4);
    write_reg(CfgInfinityCost, 32'd1000);
    send_word(CmdResetAll, 10'd0, '0);
    send_word(CmdDecrease, 10'd9, 32'd1);
    send_word(CmdReadCost, 10'd9, '0);
    send_word(CmdDecrease, 10'd3, 32'd7);
    send_word(CmdRemoveMin, 10'd0, '0);
    wait_idle();

    // zero entries acts as one: single-entry removal
    write_reg(CfgNodesUsed, 32'd0);
    write_reg(CfgInfinityCost, 32'd0);
    send_word(CmdResetAll, 10'd0, '0);
    send_word(CmdRemoveMin, 10'd0, '0);
    send_word(CmdRemoveMin, 10'd0, '0);
    send_word(CmdDecrease, 10'd0, 32'd1);
    wait_idle();

    // oversize entry count clamps to capacity
    write_reg(CfgNodesUsed, 32'h7FF);
    write_reg(CfgInfinityCost, 32'hFFFF_FFFF);
    send_word(CmdResetAll, 10'd0, '0);
    random_phase(NODES, 120, 32'hFFFF_FFFF);
    wait_idle();

    write_reg(CfgNodesUsed, 32'd16);
    write_reg(CfgInfinityCost, 32'd500);
    send_word(CmdResetAll, 10'd0, '0);
    // receiver holds off while this traffic keeps coming
    hold_go = 1'b1;
    random_phase(16, 200, 32'd600);
    wait_idle();

    write_reg(CfgNodesUsed, 32'd1);
    random_phase(2, 40, 32'd600);
    wait_idle();

    write_reg(CfgNodesUsed, 32'd1024);
    write_reg(CfgInfinityCost, 32'h8000_0000);
    random_phase(NODES, 120, 32'hFFFF_FFFF);
    wait_idle();

    write_reg(CfgNodesUsed, 32'd100);
    write_reg(CfgInfinityCost, 32'h0000_FFFF);
    send_word(CmdResetAll, 10'd0, '0);
    random_phase(100, 120, 32'h0001_0000);
    cmd_if.valid <= 1'b0;

    leftover = 0;
    while (pending_results != 0 && leftover < 200000) begin
      @(posedge clk_i);
      leftover++;
    end
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending_results == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
